// ===== rtl/engine_aux_output_controller_assert.svh =====
// Assertion macros shared by the controller RTL.
`ifndef ENGINE_AUX_OUTPUT_CONTROLLER_ASSERT_SVH
`define ENGINE_AUX_OUTPUT_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define EAOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eaoc assertion failed");

// next-cycle implication
`define EAOC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("eaoc assertion failed");

`endif

// ===== rtl/eaoc_pkg.sv =====
// Package: widths, register map, reset values and types of the aux output controller.
package eaoc_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned TempW  = 13;
  localparam int unsigned RpmW   = 14;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned RunonW = 24;
  localparam int unsigned PprW   = 5;
  localparam int unsigned TachoW = 19;
  localparam int unsigned ProdW  = RpmW + PprW;
  localparam int unsigned Prod5W = ProdW + 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;

  // floor(x/3) == (x * Div3Recip) >> Div3Shift for x < 2**Prod5W
  localparam int unsigned Div3Shift = Prod5W + 1;
  localparam logic [Prod5W-1:0] Div3Recip = Prod5W'((2 ** Div3Shift + 2) / 3);
  localparam int unsigned QuotW = 2 * Prod5W - Div3Shift;

  localparam logic [TimeW-1:0]  PrimeTimeRst = TimeW'(2000);
  localparam logic [TimeW-1:0]  GraceRst     = TimeW'(1000);
  localparam logic [TempW-1:0]  FanOnRst     = TempW'(3690);
  localparam logic [TempW-1:0]  FanOffRst    = TempW'(3630);
  localparam logic [RunonW-1:0] RunonRst     = RunonW'(120000);
  localparam logic [PprW-1:0]   PprRst       = PprW'(2);

  typedef enum logic [2:0] {
    REG_PRIME_TIME = 3'd0,
    REG_PUMP_GRACE = 3'd1,
    REG_FAN_ON     = 3'd2,
    REG_FAN_OFF    = 3'd3,
    REG_FAN_RUNON  = 3'd4,
    REG_TACHO_PPR  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0]  prime_time_ms;
    logic [TimeW-1:0]  pump_grace_ms;
    logic [TempW-1:0]  fan_on_dk;
    logic [TempW-1:0]  fan_off_dk;
    logic [RunonW-1:0] fan_runon_ms;
    logic [PprW-1:0]   tacho_ppr;
  } cfg_t;

endpackage

// ===== rtl/eaoc_in_if.sv =====
// Input channel: one control tick per request.
interface eaoc_in_if;
  logic                       valid;
  logic                       ready;
  logic [eaoc_pkg::TickW-1:0] tick_ms;
  logic                       crank_sync;
  logic [eaoc_pkg::TempW-1:0] coolant_dk;
  logic                       engine_running;
  logic [eaoc_pkg::RpmW-1:0]  engine_rpm;
  logic                       fault_present;

  modport source (output valid, tick_ms, crank_sync, coolant_dk, engine_running, engine_rpm,
                  fault_present, input ready);
  modport sink (input valid, tick_ms, crank_sync, coolant_dk, engine_running, engine_rpm,
                fault_present, output ready);
endinterface

// ===== rtl/eaoc_out_if.sv =====
// Output channel: switch states and tacho frequency per tick.
interface eaoc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        pump_on;
  logic                        fan_on;
  logic                        lamp_on;
  logic [eaoc_pkg::TachoW-1:0] tacho_centihz;

  modport source (output valid, pump_on, fan_on, lamp_on, tacho_centihz, input ready);
  modport sink (input valid, pump_on, fan_on, lamp_on, tacho_centihz, output ready);
endinterface

// ===== rtl/engine_aux_output_controller.sv =====
// Top level: engine auxiliary output controller (pump, fan, lamp, tacho).
//
// in_i carries one control tick per request (tick_ms, crank_sync, coolant_dk,
// engine_running, engine_rpm, fault_present); out_o returns one request per
// tick with pump_on, fan_on, lamp_on and tacho_centihz, in tick order.
// Configuration goes through the APB-style port, registers at byte 4*index;
// write it only while no tick is in flight.
// Pipeline: input register, state update and rpm*ppr*5 product, then the
// divide by three (reciprocal multiply) and saturation into the output
// register. One tick is accepted every cycle while in_i.ready is high; the
// timer and fan state update in the middle stage is the only feedback path.
// Reset clears all timers, the prime flag and the fan state, empties the
// pipeline and loads the register defaults; the pump primes again.
// When out_o stalls, a result holds in the output register while the two
// stages before it keep filling; in_i.ready drops only once all are full.
module engine_aux_output_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  eaoc_in_if.sink                    in_i,
  eaoc_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eaoc_pkg::AddrW-1:0] paddr,
  input  logic [eaoc_pkg::DataW-1:0] pwdata,
  output logic [eaoc_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  `include "engine_aux_output_controller_assert.svh"

  eaoc_pkg::cfg_t cfg;

  eaoc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake
  logic out_free, s2_free, s1_free, s2_move;
  logic s1_v_q, s2_v_q, out_v_q;

  assign out_free   = !out_v_q || out_o.ready;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign s2_move    = s1_v_q && s2_free;
  assign in_i.ready = s1_free;

  // stage 1: input register
  logic [eaoc_pkg::TickW-1:0] dt_q;
  logic                       sync_q, run_q, fault_q;
  logic [eaoc_pkg::TempW-1:0] clt_q;
  logic [eaoc_pkg::RpmW-1:0]  rpm_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_free) begin
      dt_q    <= in_i.tick_ms;
      sync_q  <= in_i.crank_sync;
      clt_q   <= in_i.coolant_dk;
      run_q   <= in_i.engine_running;
      rpm_q   <= in_i.engine_rpm;
      fault_q <= in_i.fault_present;
    end
  end

  // stage 2: controller state and rpm*ppr*5 product
  logic                        primed_q, primed_d;
  logic [eaoc_pkg::TimeW-1:0]  prime_q, prime_d;
  logic [eaoc_pkg::TimeW-1:0]  nosync_q, nosync_d;
  logic                        fan_q, fan_d;
  logic [eaoc_pkg::RunonW-1:0] runon_q, runon_d;
  logic [eaoc_pkg::TimeW:0]    prime_sum, nosync_sum;
  logic [eaoc_pkg::RunonW:0]   runon_sum;
  logic                        pump_d, below_off;
  logic [eaoc_pkg::ProdW-1:0]  prod;
  logic [eaoc_pkg::Prod5W-1:0] prod5_d;

  always_comb begin
    prime_sum  = {1'b0, prime_q} + (eaoc_pkg::TimeW + 1)'(dt_q);
    nosync_sum = {1'b0, nosync_q} + (eaoc_pkg::TimeW + 1)'(dt_q);
    runon_sum  = {1'b0, runon_q} + (eaoc_pkg::RunonW + 1)'(dt_q);
    below_off  = clt_q < cfg.fan_off_dk;

    primed_d = primed_q;
    prime_d  = prime_q;
    nosync_d = nosync_q;
    pump_d   = 1'b0;
    if (!primed_q) begin
      prime_d  = prime_sum[eaoc_pkg::TimeW] ? '1 : prime_sum[eaoc_pkg::TimeW-1:0];
      pump_d   = 1'b1;
      primed_d = prime_d >= cfg.prime_time_ms;
    end
    if (primed_d) begin
      if (sync_q) begin
        nosync_d = '0;
      end else begin
        nosync_d = nosync_sum[eaoc_pkg::TimeW] ? '1 : nosync_sum[eaoc_pkg::TimeW-1:0];
      end
      pump_d = sync_q || (nosync_d < cfg.pump_grace_ms);
    end

    fan_d   = fan_q;
    runon_d = runon_q;
    if (clt_q > cfg.fan_on_dk) begin
      fan_d = 1'b1;
    end else if (below_off && run_q) begin
      fan_d = 1'b0;
    end
    if (run_q) begin
      runon_d = '0;
    end else if (fan_d) begin
      runon_d = runon_sum[eaoc_pkg::RunonW] ? '1 : runon_sum[eaoc_pkg::RunonW-1:0];
      if (runon_d > cfg.fan_runon_ms || below_off) begin
        fan_d = 1'b0;
      end
    end

    prod    = eaoc_pkg::ProdW'(rpm_q) * eaoc_pkg::ProdW'(cfg.tacho_ppr);
    prod5_d = {1'b0, prod, 2'b00} + eaoc_pkg::Prod5W'(prod);
  end

  logic                        pump_q, fan_s2_q, lamp_q;
  logic [eaoc_pkg::Prod5W-1:0] prod5_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      pump_q   <= pump_d;
      fan_s2_q <= fan_d;
      lamp_q   <= fault_q;
      prod5_q  <= prod5_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      prime_q  <= '0;
      nosync_q <= '0;
      fan_q    <= 1'b0;
      runon_q  <= '0;
    end else if (s2_move) begin
      primed_q <= primed_d;
      prime_q  <= prime_d;
      nosync_q <= nosync_d;
      fan_q    <= fan_d;
      runon_q  <= runon_d;
    end
  end

  // stage 3: divide by three, saturate, output register
  logic [2*eaoc_pkg::Prod5W-1:0] recip_prod;
  logic [eaoc_pkg::QuotW-1:0]    quot;
  logic [eaoc_pkg::TachoW-1:0]   tacho_d;

  always_comb begin
    recip_prod = (2 * eaoc_pkg::Prod5W)'(prod5_q) * (2 * eaoc_pkg::Prod5W)'(eaoc_pkg::Div3Recip);
    quot       = recip_prod[2*eaoc_pkg::Prod5W-1:eaoc_pkg::Div3Shift];
    if (|quot[eaoc_pkg::QuotW-1:eaoc_pkg::TachoW]) begin
      tacho_d = '1;
    end else begin
      tacho_d = quot[eaoc_pkg::TachoW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_v_q) begin
      out_o.pump_on       <= pump_q;
      out_o.fan_on        <= fan_s2_q;
      out_o.lamp_on       <= lamp_q;
      out_o.tacho_centihz <= tacho_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_i.valid;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_free) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign out_o.valid = out_v_q;

  `EAOC_ASSERT_NXT(a_primed_sticky, primed_q, primed_q)
  `EAOC_ASSERT_IMP(a_nosync_idle_while_priming, !primed_q, nosync_q == '0)
  `EAOC_ASSERT_NXT(a_runon_clear_when_running, s2_move && run_q, runon_q == '0)
  `EAOC_ASSERT_NXT(a_s2_drains_to_out, s2_v_q && out_free, out_v_q)

endmodule

// ===== rtl/eaoc_regs.sv =====
// APB-style configuration register file of the aux output controller.
module eaoc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eaoc_pkg::AddrW-1:0] paddr,
  input  logic [eaoc_pkg::DataW-1:0] pwdata,
  output logic [eaoc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output eaoc_pkg::cfg_t             cfg_o
);

  eaoc_pkg::cfg_t     cfg_q, cfg_d;
  eaoc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = eaoc_pkg::reg_idx_e'(paddr[eaoc_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        eaoc_pkg::REG_PRIME_TIME: cfg_d.prime_time_ms = pwdata[eaoc_pkg::TimeW-1:0];
        eaoc_pkg::REG_PUMP_GRACE: cfg_d.pump_grace_ms = pwdata[eaoc_pkg::TimeW-1:0];
        eaoc_pkg::REG_FAN_ON:     cfg_d.fan_on_dk     = pwdata[eaoc_pkg::TempW-1:0];
        eaoc_pkg::REG_FAN_OFF:    cfg_d.fan_off_dk    = pwdata[eaoc_pkg::TempW-1:0];
        eaoc_pkg::REG_FAN_RUNON:  cfg_d.fan_runon_ms  = pwdata[eaoc_pkg::RunonW-1:0];
        eaoc_pkg::REG_TACHO_PPR:  cfg_d.tacho_ppr     = pwdata[eaoc_pkg::PprW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      eaoc_pkg::REG_PRIME_TIME: prdata = eaoc_pkg::DataW'(cfg_q.prime_time_ms);
      eaoc_pkg::REG_PUMP_GRACE: prdata = eaoc_pkg::DataW'(cfg_q.pump_grace_ms);
      eaoc_pkg::REG_FAN_ON:     prdata = eaoc_pkg::DataW'(cfg_q.fan_on_dk);
      eaoc_pkg::REG_FAN_OFF:    prdata = eaoc_pkg::DataW'(cfg_q.fan_off_dk);
      eaoc_pkg::REG_FAN_RUNON:  prdata = eaoc_pkg::DataW'(cfg_q.fan_runon_ms);
      eaoc_pkg::REG_TACHO_PPR:  prdata = eaoc_pkg::DataW'(cfg_q.tacho_ppr);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prime_time_ms <= eaoc_pkg::PrimeTimeRst;
      cfg_q.pump_grace_ms <= eaoc_pkg::GraceRst;
      cfg_q.fan_on_dk     <= eaoc_pkg::FanOnRst;
      cfg_q.fan_off_dk    <= eaoc_pkg::FanOffRst;
      cfg_q.fan_runon_ms  <= eaoc_pkg::RunonRst;
      cfg_q.tacho_ppr     <= eaoc_pkg::PprRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
